>>> rtl/bsd_pkg.sv
`timescale 1ns / 1ps

package bsd_pkg;

  // Largest accepted width and height; dimension fields carry 13 bits
  localparam int unsigned DimW   = 13;
  localparam int unsigned IdxW   = 24;
  localparam logic [31:0] MaxDim = 32'd4096;

  // Header constants
  localparam logic [15:0] MagicBm  = 16'd19778;
  localparam logic [15:0] Depth24  = 16'd24;
  localparam logic [15:0] Depth32  = 16'd32;
  localparam logic [31:0] PixStart = 32'd54;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_BAD_DEPTH = 2'd2,
    ST_BAD_DIM   = 2'd3
  } status_e;

  // Classified event passed from the parser to the output stage
  typedef struct packed {
    kind_e            kind;
    status_e          status;
    logic             last;
    logic             alpha_en;
    logic [DimW-1:0]  width;
    logic [DimW-1:0]  height;
    logic [IdxW-1:0]  index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
  } evt_t;

endpackage

>>> rtl/bsd_front.sv
`timescale 1ns / 1ps

module bsd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic [7:0]    data_i,
  input  logic          new_file_i,
  output logic          evt_valid_o,
  output bsd_pkg::evt_t evt_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_DONE
  } phase_e;

  // Header byte positions
  localparam logic [5:0] BMagicLo = 6'd0;
  localparam logic [5:0] BMagicHi = 6'd1;
  localparam logic [5:0] BOffLo   = 6'd10;
  localparam logic [5:0] BOffHi   = 6'd13;
  localparam logic [5:0] BWidLo   = 6'd18;
  localparam logic [5:0] BWidHi   = 6'd21;
  localparam logic [5:0] BHgtLo   = 6'd22;
  localparam logic [5:0] BHgtHi   = 6'd25;
  localparam logic [5:0] BArea    = 6'd26;
  localparam logic [5:0] BBppLo   = 6'd28;
  localparam logic [5:0] BBppHi   = 6'd29;
  localparam logic [5:0] BLast    = 6'd53;

  phase_e       phase_q, phase_d, phase_cur;
  logic [31:0]  byte_cnt_q, byte_cnt_d;
  logic [15:0]  field_q, field_d;
  logic [31:0]  offset_q, offset_d;
  logic [31:0]  width_q, width_d;
  logic [31:0]  height_q, height_d;
  logic         depth32_q, depth32_d;
  logic [12:0]  column_q, column_d;
  logic [23:0]  dest_q, dest_d;
  logic [24:0]  left_q, left_d;
  logic [1:0]   chan_q, chan_d;
  logic [1:0]   pad_q, pad_d;
  logic [7:0]   blue_q, blue_d;
  logic [7:0]   green_q, green_d;
  logic [7:0]   red_q, red_d;

  logic [5:0]   hb;
  logic [1:0]   lane;
  logic [32:0]  cnt_inc;
  logic [25:0]  area;
  logic [25:0]  top_row;
  logic [12:0]  h_m1;
  logic [12:0]  col_inc;
  logic [23:0]  dest_inc;

  // Header position; the header never runs past byte 53
  assign hb      = (new_file_i) ? 6'd0 : byte_cnt_q[5:0];
  assign lane    = hb[1:0] + 2'd2;
  assign cnt_inc = {1'b0, byte_cnt_q} + 33'd1;
  assign h_m1    = height_q[12:0] - 13'd1;
  assign area    = 26'(width_q[12:0]) * 26'(height_q[12:0]);
  assign top_row = 26'(h_m1) * 26'(width_q[12:0]);
  assign col_inc = column_q + 13'd1;
  assign dest_inc = dest_q + 24'd1;

  // Parse bytes and classify them into events
  always_comb begin
    phase_d    = phase_q;
    byte_cnt_d = byte_cnt_q;
    field_d    = field_q;
    offset_d   = offset_q;
    width_d    = width_q;
    height_d   = height_q;
    depth32_d  = depth32_q;
    column_d   = column_q;
    dest_d     = dest_q;
    left_d     = left_q;
    chan_d     = chan_q;
    pad_d      = pad_q;
    blue_d     = blue_q;
    green_d    = green_q;
    red_d      = red_q;

    evt_valid_o     = 1'b0;
    evt_o.kind      = bsd_pkg::KIND_PIXEL;
    evt_o.status    = bsd_pkg::ST_OK;
    evt_o.last      = 1'b0;
    evt_o.alpha_en  = depth32_q;
    evt_o.width     = width_q[12:0];
    evt_o.height    = height_q[12:0];
    evt_o.index     = dest_q;
    evt_o.red       = red_q;
    evt_o.green     = green_q;
    evt_o.blue      = blue_q;
    evt_o.alpha     = data_i;

    phase_cur = (new_file_i) ? PH_HEADER : phase_q;

    if (in_fire_i) begin
      phase_d = phase_cur;
      unique case (phase_cur)
        PH_HEADER: begin
          // Gather header fields
          if (hb == BMagicLo || hb == BBppLo) begin
            field_d = {8'd0, data_i};
          end else if (hb == BMagicHi || hb == BBppHi) begin
            field_d = {data_i, field_q[7:0]};
          end else if (hb >= BOffLo && hb <= BOffHi) begin
            offset_d[{lane, 3'b000} +: 8] = data_i;
          end else if (hb >= BWidLo && hb <= BWidHi) begin
            width_d[{lane, 3'b000} +: 8] = data_i;
          end else if (hb >= BHgtLo && hb <= BHgtHi) begin
            height_d[{lane, 3'b000} +: 8] = data_i;
          end
          byte_cnt_d = {26'd0, hb} + 32'd1;

          // Precompute pixel count and first destination once sizes are in
          if (hb == BArea) begin
            left_d = area[24:0];
            dest_d = (height_q[12:0] == 13'd0) ? 24'd0 : top_row[23:0];
          end

          if (hb == BOffHi && field_q != bsd_pkg::MagicBm) begin
            phase_d      = PH_DONE;
            evt_valid_o  = 1'b1;
            evt_o.kind   = bsd_pkg::KIND_ERROR;
            evt_o.status = bsd_pkg::ST_BAD_MAGIC;
          end else if (hb == BLast) begin
            evt_valid_o = 1'b1;
            if (field_q != bsd_pkg::Depth24 && field_q != bsd_pkg::Depth32) begin
              phase_d      = PH_DONE;
              evt_o.kind   = bsd_pkg::KIND_ERROR;
              evt_o.status = bsd_pkg::ST_BAD_DEPTH;
            end else if (width_q > bsd_pkg::MaxDim || height_q > bsd_pkg::MaxDim) begin
              phase_d      = PH_DONE;
              evt_o.kind   = bsd_pkg::KIND_ERROR;
              evt_o.status = bsd_pkg::ST_BAD_DIM;
            end else begin
              evt_o.kind = bsd_pkg::KIND_HEADER;
              depth32_d  = (field_q == bsd_pkg::Depth32);
              column_d   = 13'd0;
              chan_d     = 2'd0;
              if (width_q == 32'd0 || height_q == 32'd0) begin
                phase_d = PH_DONE;
              end else if (offset_q > bsd_pkg::PixStart) begin
                phase_d = PH_SKIP;
              end else begin
                phase_d = PH_PIXEL;
              end
            end
          end
        end

        PH_SKIP: begin
          // Drop bytes up to the pixel data offset
          byte_cnt_d = cnt_inc[31:0];
          if (cnt_inc >= {1'b0, offset_q}) begin
            phase_d = PH_PIXEL;
          end
        end

        PH_PAD: begin
          // Drop row padding
          pad_d = pad_q - 2'd1;
          if (pad_q == 2'd1) begin
            phase_d = PH_PIXEL;
          end
        end

        PH_PIXEL: begin
          priority if (chan_q == 2'd0) begin
            blue_d = data_i;
            chan_d = 2'd1;
          end else if (chan_q == 2'd1) begin
            green_d = data_i;
            chan_d  = 2'd2;
          end else if (chan_q == 2'd2 && depth32_q) begin
            red_d  = data_i;
            chan_d = 2'd3;
          end else begin
            // Final byte of a pixel: emit it
            if (chan_q == 2'd2) begin
              red_d     = data_i;
              evt_o.red = data_i;
            end
            chan_d      = 2'd0;
            evt_valid_o = 1'b1;
            evt_o.kind  = bsd_pkg::KIND_PIXEL;
            evt_o.last  = (left_q == 25'd1);
            left_d      = left_q - 25'd1;
            column_d    = col_inc;
            dest_d      = dest_inc;
            if (left_q == 25'd1) begin
              phase_d = PH_DONE;
            end else if (col_inc == width_q[12:0]) begin
              column_d = 13'd0;
              dest_d   = dest_inc - {10'd0, width_q[12:0], 1'b0};
              if (!depth32_q && width_q[1:0] != 2'd0) begin
                pad_d   = width_q[1:0];
                phase_d = PH_PAD;
              end
            end
          end
        end

        PH_IDLE, PH_DONE: begin
          phase_d = phase_cur;
        end

        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      byte_cnt_q <= '0;
      field_q    <= '0;
      offset_q   <= '0;
      width_q    <= '0;
      height_q   <= '0;
      depth32_q  <= 1'b0;
      column_q   <= '0;
      dest_q     <= '0;
      left_q     <= '0;
      chan_q     <= '0;
      pad_q      <= '0;
      blue_q     <= '0;
      green_q    <= '0;
      red_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      field_q    <= field_d;
      offset_q   <= offset_d;
      width_q    <= width_d;
      height_q   <= height_d;
      depth32_q  <= depth32_d;
      column_q   <= column_d;
      dest_q     <= dest_d;
      left_q     <= left_d;
      chan_q     <= chan_d;
      pad_q      <= pad_d;
      blue_q     <= blue_d;
      green_q    <= green_d;
      red_q      <= red_d;
    end
  end

  a_evt_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_o |-> in_fire_i)
    else $error("event raised without an accepted byte");

  a_alpha_chan_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIXEL && chan_q == 2'd3) |-> depth32_q)
    else $error("alpha byte expected on a 24-bit image");

endmodule

>>> rtl/bsd_queue.sv
`timescale 1ns / 1ps

module bsd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bsd_pkg::evt_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bsd_pkg::evt_t pop_data_o
);

  bsd_pkg::evt_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("event queue overflow");

endmodule

>>> rtl/bsd_back.sv
`timescale 1ns / 1ps

module bsd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          evt_empty_i,
  input  bsd_pkg::evt_t evt_i,
  output logic          evt_pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [87:0]   m_axis_tdata,  // status, image_width, image_height, pixel_index,
                                       // red, green, blue, alpha, zero fill
  output logic [1:0]    m_axis_tuser,  // kind
  output logic          m_axis_tlast   // last_pixel
);

  logic          valid_q, valid_d;
  logic [87:0]   data_q, data_d;
  logic [1:0]    kind_q, kind_d;
  logic          last_q, last_d;
  logic          is_pix, is_hdr;
  logic [7:0]    alpha;

  assign evt_pop_o = !evt_empty_i && (!valid_q || m_axis_tready);
  assign is_pix    = (evt_i.kind == bsd_pkg::KIND_PIXEL);
  assign is_hdr    = (evt_i.kind == bsd_pkg::KIND_HEADER);
  assign alpha     = evt_i.alpha_en ? evt_i.alpha : bsd_pkg::AlphaOpaque;

  // Format the event into a result item, zeroing fields unused by its kind
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    kind_d  = kind_q;
    last_d  = last_q;
    if (evt_pop_o) begin
      valid_d = 1'b1;
      kind_d  = evt_i.kind;
      last_d  = is_pix && evt_i.last;
      data_d  = {4'd0,
                 is_pix ? alpha       : 8'd0,
                 is_pix ? evt_i.blue  : 8'd0,
                 is_pix ? evt_i.green : 8'd0,
                 is_pix ? evt_i.red   : 8'd0,
                 is_pix ? evt_i.index : 24'd0,
                 is_hdr ? evt_i.height : 13'd0,
                 is_hdr ? evt_i.width  : 13'd0,
                 evt_i.status};
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  // Hold the output item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    kind_q <= kind_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

  a_last_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == bsd_pkg::KIND_PIXEL))
    else $error("last flag on a non-pixel item");

endmodule

>>> rtl/bmp_stream_decoder.sv
`timescale 1ns / 1ps

// BMP stream decoder.
// Input stream: one file byte per item in s_axis_tdata[7:0]; s_axis_tuser high
// marks byte 0 of a new file and restarts the parser at any time. Bytes that
// arrive with no file open, or after an image or error ends, are dropped.
// Output stream: one item per header (kind 0, with width and height), per
// pixel (kind 1, RGBA with top-down index, tlast on the final pixel) or per
// error (kind 2, with status). Most bytes produce no item; a pixel item
// follows its last color byte.
// Throughput: one byte per cycle while the event queue is not full. An item
// passes from the parser into a two-entry event queue, where it is registered,
// and from there into the output register.
// When the receiver stalls, items wait in the output register and the queue;
// s_axis_tready drops only when the queue is full.
// Reset empties the queue and output register and leaves the parser idle,
// waiting for a byte with s_axis_tuser high.
module bmp_stream_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // data_byte
  input  logic         s_axis_tuser,  // new_file
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata,  // status, image_width, image_height, pixel_index,
                                      // red, green, blue, alpha, zero fill
  output logic [1:0]   m_axis_tuser,  // kind
  output logic         m_axis_tlast   // last_pixel
);

  logic          in_fire;
  logic          evt_valid;
  bsd_pkg::evt_t evt_in;
  bsd_pkg::evt_t evt_out;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;

  assign s_axis_tready = !q_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  bsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .data_i      (s_axis_tdata),
    .new_file_i  (s_axis_tuser),
    .evt_valid_o (evt_valid),
    .evt_o       (evt_in)
  );

  bsd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (evt_valid),
    .push_data_i (evt_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (evt_out)
  );

  bsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .evt_empty_i   (q_empty),
    .evt_i         (evt_out),
    .evt_pop_o     (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
